// ----- hdl/bad2x_pkg.sv -----
// Shared types and constants for the 2x2 box-average downscaler.
// No dependencies; imported by bad2x_scan, bad2x_out and the top level.
`default_nettype none

package bad2x_pkg;

  // Fixed field and register widths
  localparam int CH_W      = 16;
  localparam int NUM_CH    = 3;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_W     = 12;
  localparam int ROW_LIMIT = 4096;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  // Register reset values
  localparam logic [CFG_W-1:0] IN_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] IN_HEIGHT_RST = 13'd480;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 1'b1;

  // Line-store operation issued by the scan stage for one accepted item
  typedef struct packed {
    logic wr;    // store the pair sum (even row)
    logic rd;    // fetch the stored pair sum and emit a result (odd row)
    logic last;  // result is the final pixel of the output frame
  } bad2x_op_t;

endpackage

`default_nettype wire

// ----- hdl/bad2x_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bad2x_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bad2x_scan.sv -----
// Scan stage: size registers, column/row counters, held pixel and pair sums.
// Issues one line-store write or read per accepted item that closes a pair. Uses bad2x_pkg.
`default_nettype none

module bad2x_scan import bad2x_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int LineDepth = MAX_WIDTH / 2,
  localparam int AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1,
  localparam int ColW      = ($clog2(MAX_WIDTH) > AddrW) ? $clog2(MAX_WIDTH) : AddrW + 1,
  localparam int SzW       = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W,
  localparam int PairW     = SAMPLE_BITS + 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_W-1:0]        cfg_data_i,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_ready_i,
  input  wire logic [NUM_CH*CH_W-1:0]  in_data_i,
  output bad2x_op_t                    op_o,
  output logic      [AddrW-1:0]        addr_o,
  output logic      [NUM_CH*PairW-1:0] pair_o
);

  logic [CFG_W-1:0]              in_width_q, in_height_q;
  logic [ColW-1:0]               col_q, col_d;
  logic [ROW_W-1:0]              row_q, row_d;
  logic [NUM_CH*SAMPLE_BITS-1:0] held_q, held_d, px;
  logic                          accept;
  logic [SzW-1:0]                w_raw, w, ew, c_ext, c_inc;
  logic [CFG_W-1:0]              h, eh, r_ext, r_inc;
  logic                          in_blk;

  assign accept = in_valid_i & in_ready_i;

  // Size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q  <= IN_WIDTH_RST;
      in_height_q <= IN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IN_WIDTH:  in_width_q  <= cfg_data_i;
        REG_IN_HEIGHT: in_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, saturate at the limits
  always_comb begin
    w_raw = SzW'(in_width_q);
    if (in_width_q == '0) begin
      w = SzW'(1);
    end else if (w_raw > SzW'(MAX_WIDTH)) begin
      w = SzW'(MAX_WIDTH);
    end else begin
      w = w_raw;
    end
    if (in_height_q == '0) begin
      h = CFG_W'(1);
    end else if (in_height_q > CFG_W'(ROW_LIMIT)) begin
      h = CFG_W'(ROW_LIMIT);
    end else begin
      h = in_height_q;
    end
    ew = {w[SzW-1:1], 1'b0};
    eh = {h[CFG_W-1:1], 1'b0};
  end

  // Mask samples and form the horizontal pair sums
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      px[k*SAMPLE_BITS +: SAMPLE_BITS] = in_data_i[k*CH_W +: SAMPLE_BITS];
      pair_o[k*PairW +: PairW] = PairW'(held_q[k*SAMPLE_BITS +: SAMPLE_BITS])
                               + PairW'(px[k*SAMPLE_BITS +: SAMPLE_BITS]);
    end
  end

  // Classify the item: odd column inside the even-sized area closes a pair
  always_comb begin
    c_ext   = SzW'(col_q);
    c_inc   = c_ext + SzW'(1);
    r_ext   = CFG_W'(row_q);
    r_inc   = r_ext + CFG_W'(1);
    in_blk  = col_q[0] & (c_ext < ew) & (r_ext < eh);
    op_o.wr   = accept & in_blk & ~row_q[0];
    op_o.rd   = accept & in_blk & row_q[0];
    op_o.last = (c_ext == ew - SzW'(1)) && (r_ext == eh - CFG_W'(1));
    addr_o    = col_q[AddrW:1];
  end

  // Advance counters and hold the even-column pixel
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    held_d = held_q;
    if (accept) begin
      if (!col_q[0]) begin
        held_d = px;
      end
      if (c_inc >= w) begin
        col_d = '0;
        row_d = (r_inc >= h) ? '0 : ROW_W'(r_inc);
      end else begin
        col_d = ColW'(c_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      held_q <= held_d;
    end
  end

  // A single item never both stores and fetches
  a_op_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(op_o.wr && op_o.rd))
    else $error("line store write and read issued together");

  // Line-store traffic only on an accepted odd-column item
  a_op_on_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_o.wr || op_o.rd) |-> (accept && col_q[0]))
    else $error("line store access outside an odd-column item");

endmodule

`default_nettype wire

// ----- hdl/bad2x_out.sv -----
// Output stage: holds the current pair sum in stage one during the line-store read, adds the two pair
// sums, divides by four and registers the result. Uses bad2x_pkg.
`default_nettype none

module bad2x_out import bad2x_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int PairW = SAMPLE_BITS + 1,
  localparam int SumW  = SAMPLE_BITS + 2
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire bad2x_op_t               op_i,
  input  wire logic [NUM_CH*PairW-1:0] pair_i,
  input  wire logic [NUM_CH*PairW-1:0] rdata_i,
  output logic                         s1_free_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic      [NUM_CH*CH_W-1:0]  out_data_o,
  output logic                         out_last_o
);

  logic                     s1_valid_q, s1_valid_d;
  logic [NUM_CH*PairW-1:0]  s1_pair_q;
  logic                     s1_last_q;
  logic                     out_valid_q, out_valid_d;
  logic [NUM_CH*CH_W-1:0]   out_data_q, out_data_d;
  logic                     out_last_q;
  logic                     out_free, s1_move;
  logic [SumW-1:0]          sum;

  assign out_free  = ~out_valid_q | out_ready_i;
  assign s1_free_o = ~s1_valid_q | out_free;
  assign s1_move   = s1_valid_q & out_free;

  // Combine stored and current pair sums, truncate the mean
  always_comb begin
    sum = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      sum = SumW'(rdata_i[k*PairW +: PairW]) + SumW'(s1_pair_q[k*PairW +: PairW]);
      out_data_d[k*CH_W +: CH_W] = CH_W'(sum[SumW-1:2]);
    end
  end

  // Valid flags: load stage one on a read, drain into the output register
  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
    end
    if (s1_free_o) begin
      s1_valid_d = op_i.rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (op_i.rd) begin
      s1_pair_q <= pair_i;
      s1_last_q <= op_i.last;
    end
    if (s1_move) begin
      out_data_q <= out_data_d;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  // A fetch is only issued when stage one can take it
  a_rd_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i.rd |-> s1_free_o)
    else $error("line store read issued while stage one is blocked");

  // A blocked stage one keeps its item
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q)
    else $error("stage one item lost while stalled");

  // A taken result with nothing behind it empties the output register
  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !s1_valid_q) |=> !out_valid_q)
    else $error("result repeated after it was taken");

endmodule

`default_nettype wire

// ----- hdl/box_average_downscale_2x.sv -----
// 2x2 box-average downscaler, top level. The odd-row, odd-column pixel closing
// a block goes into stage one with the line-store read, its result into the
// output register. One pixel per cycle unless the output stalls; the line
// store does one write (even rows) or one read (odd rows) per odd-column pixel
// on its two ports. Reset: counters, held pixel and valid flags clear, size is
// 640x480; the line store is not cleared, each entry is written before read.
`default_nettype none

module box_average_downscale_2x import bad2x_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int LineDepth = MAX_WIDTH / 2,
  localparam int AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1,
  localparam int PairW     = SAMPLE_BITS + 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration writes
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i,
  // Input pixels
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [NUM_CH*CH_W-1:0] s_axis_tdata,   // in_ch0, in_ch1, in_ch2
  // Output pixels
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [NUM_CH*CH_W-1:0] m_axis_tdata,   // out_ch0, out_ch1, out_ch2
  output logic                        m_axis_tlast    // frame_end
);

  bad2x_op_t                 op;
  logic [AddrW-1:0]          addr;
  logic [NUM_CH*PairW-1:0]   pair, rdata;
  logic                      s1_free;

  assign s_axis_tready = s1_free;

  bad2x_scan #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_i (s1_free),
    .in_data_i  (s_axis_tdata),
    .op_o       (op),
    .addr_o     (addr),
    .pair_o     (pair)
  );

  bad2x_ram #(
    .Width (NUM_CH * PairW),
    .Depth (LineDepth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (op.wr),
    .waddr_i (addr),
    .wdata_i (pair),
    .re_i    (op.rd),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  bad2x_out #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .pair_i      (pair),
    .rdata_i     (rdata),
    .s1_free_o   (s1_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
